FILE: hdl/svpwm_pkg.sv
package svpwm_pkg;

  // Quarter-wave sine table: SINE_DEPTH + 1 entries, addressed by the top
  // SINE_ADDR_BITS bits of the angle within a quadrant.
  localparam int SINE_ADDR_BITS = 8;
  localparam int SINE_DEPTH     = 1 << SINE_ADDR_BITS;

  localparam logic signed [63:0] HALF_PI_Q30    = 64'sd1686629713;
  localparam logic signed [17:0] SQRT3_HALF_Q15 = 18'sd28378;

  // Register indexes on the configuration channel.
  localparam logic [1:0] REG_AMPLITUDE  = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [1:0] REG_PWM_PERIOD = 2'd2;

  localparam logic [14:0] AMPLITUDE_RESET  = 15'd2294;
  localparam logic [15:0] PHASE_STEP_RESET = 16'd83;
  localparam logic [15:0] PWM_PERIOD_RESET = 16'd4250;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COS,
    ST_SIN,
    ST_ROT,
    ST_MIX,
    ST_INJ,
    ST_DU,
    ST_DV,
    ST_DW,
    ST_DONE
  } seq_state_t;

  // Table entry k = round(32767 * sin(pi/2 * k / SINE_DEPTH)), from a Q30
  // Taylor series. Only ever called with constant arguments.
  function automatic longint rom_entry(input int k);
    longint th;
    longint th2;
    longint term;
    longint sum;
    longint v;
    th   = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
    th2  = (th * th) >>> 30;
    term = th;
    sum  = th;
    term = ((term * th2) >>> 30) / 6;
    sum  = sum - term;
    term = ((term * th2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * th2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * th2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * th2) >>> 30) / 110;
    sum  = sum - term;
    term = ((term * th2) >>> 30) / 156;
    sum  = sum + term;
    term = ((term * th2) >>> 30) / 210;
    sum  = sum - term;
    term = ((term * th2) >>> 30) / 272;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v;
  endfunction

endpackage

FILE: hdl/open_loop_svpwm_modulator.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[0] = tick
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata = duty_u, duty_v, duty_w, angle
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A tick is accepted only in the idle state, so a new tick cannot start until
// the previous result has been loaded into the output register. The six
// multiplications of an item all go through one 18x18 multiplier whose
// product is registered, with a compare step for the common-mode offset.
// Reset clears the phase accumulator and loads the register defaults.
// A finished result waits in the output register; the sequencer stalls in
// its last step only if an earlier result has still not been taken.
module open_loop_svpwm_modulator #(
  parameter int PHASE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // duty_u, duty_v, duty_w, electrical_angle
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  svpwm_pkg::seq_state_t state;
  svpwm_pkg::seq_state_t state_next;

  logic [14:0]           amplitude;
  logic [15:0]           phase_step;
  logic [15:0]           pwm_period;
  logic [PHASE_BITS-1:0] acc;
  logic [PHASE_BITS-1:0] step_ext;
  logic [15:0]           angle;

  logic [15:0]           sine_angle;
  logic signed [15:0]    sine;
  logic signed [17:0]    mul_a;
  logic signed [17:0]    mul_b;
  logic signed [35:0]    prod;
  logic signed [35:0]    prod_rnd;
  logic signed [35:0]    half_alpha;
  logic signed [35:0]    vb_sum;
  logic signed [35:0]    vc_sum;

  logic signed [17:0]    alpha;
  logic signed [17:0]    vb;
  logic signed [17:0]    vc;
  logic signed [17:0]    vmax;
  logic signed [17:0]    vmin;
  logic signed [18:0]    mm_sum;
  logic signed [17:0]    cm;
  logic [16:0]           s_u;
  logic [16:0]           s_v;
  logic [16:0]           s_w;
  logic [15:0]           duty_u;
  logic [15:0]           duty_v;
  logic                  load_out;

  if (PHASE_BITS >= 16) begin : g_wide
    assign step_ext = PHASE_BITS'(phase_step);
    assign angle    = acc[PHASE_BITS-1 -: 16];
  end else begin : g_narrow
    assign step_ext = phase_step[PHASE_BITS-1:0];
    assign angle    = {acc, (16 - PHASE_BITS)'(0)};
  end

  // Shift the phase by a quarter turn to read cosine from the sine table.
  assign sine_angle = (state == svpwm_pkg::ST_COS) ? angle + 16'd16384 : angle;

  svpwm_sine u_sine (
    .angle (sine_angle),
    .sine  (sine)
  );

  svpwm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  function automatic logic [16:0] level(input logic signed [17:0] v,
                                        input logic signed [17:0] c);
    logic signed [19:0] s;
    s = 20'(v) - 20'(c) + 20'sd32768;
    if (s < 0) begin
      return 17'd0;
    end else if (s > 20'sd65536) begin
      return 17'd65536;
    end
    return s[16:0];
  endfunction

  assign prod_rnd   = prod + 36'sd16384;
  assign half_alpha = {{4{alpha[17]}}, alpha, 14'b0};
  assign vb_sum     = prod - half_alpha + 36'sd16384;
  assign vc_sum     = -prod - half_alpha + 36'sd16384;

  always_comb begin
    vmax = alpha;
    vmin = alpha;
    if (vb > vmax) vmax = vb;
    if (vc > vmax) vmax = vc;
    if (vb < vmin) vmin = vb;
    if (vc < vmin) vmin = vc;
    mm_sum = 19'(vmax) + 19'(vmin);
    cm     = mm_sum[18:1];
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      svpwm_pkg::ST_IDLE: if (s_axis_tvalid) state_next = svpwm_pkg::ST_COS;
      svpwm_pkg::ST_COS:  state_next = svpwm_pkg::ST_SIN;
      svpwm_pkg::ST_SIN:  state_next = svpwm_pkg::ST_ROT;
      svpwm_pkg::ST_ROT:  state_next = svpwm_pkg::ST_MIX;
      svpwm_pkg::ST_MIX:  state_next = svpwm_pkg::ST_INJ;
      svpwm_pkg::ST_INJ:  state_next = svpwm_pkg::ST_DU;
      svpwm_pkg::ST_DU:   state_next = svpwm_pkg::ST_DV;
      svpwm_pkg::ST_DV:   state_next = svpwm_pkg::ST_DW;
      svpwm_pkg::ST_DW:   state_next = svpwm_pkg::ST_DONE;
      svpwm_pkg::ST_DONE: if (load_out) state_next = svpwm_pkg::ST_IDLE;
      default:            state_next = svpwm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    load_out      = 1'b0;
    case (state)
      svpwm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      svpwm_pkg::ST_COS, svpwm_pkg::ST_SIN: begin
        mul_a = $signed({3'b0, amplitude});
        mul_b = 18'(sine);
      end
      svpwm_pkg::ST_ROT: begin
        // The sine product from the last step, rounded, is beta.
        mul_a = svpwm_pkg::SQRT3_HALF_Q15;
        mul_b = prod_rnd[32:15];
      end
      svpwm_pkg::ST_DU: begin
        mul_a = $signed({1'b0, s_u});
        mul_b = $signed({2'b0, pwm_period});
      end
      svpwm_pkg::ST_DV: begin
        mul_a = $signed({1'b0, s_v});
        mul_b = $signed({2'b0, pwm_period});
      end
      svpwm_pkg::ST_DW, svpwm_pkg::ST_DONE: begin
        // Keep issuing phase W so the product holds while the output stalls.
        mul_a    = $signed({1'b0, s_w});
        mul_b    = $signed({2'b0, pwm_period});
        load_out = (state == svpwm_pkg::ST_DONE) && (!m_axis_tvalid || m_axis_tready);
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= svpwm_pkg::ST_IDLE;
      acc           <= '0;
      amplitude     <= svpwm_pkg::AMPLITUDE_RESET;
      phase_step    <= svpwm_pkg::PHASE_STEP_RESET;
      pwm_period    <= svpwm_pkg::PWM_PERIOD_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) begin
        acc <= acc + step_ext;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          svpwm_pkg::REG_AMPLITUDE:  amplitude  <= cfg_data[14:0];
          svpwm_pkg::REG_PHASE_STEP: phase_step <= cfg_data;
          svpwm_pkg::REG_PWM_PERIOD: pwm_period <= cfg_data;
          default:                   ;
        endcase
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      svpwm_pkg::ST_SIN: alpha <= prod_rnd[32:15];
      svpwm_pkg::ST_MIX: begin
        vb <= vb_sum[32:15];
        vc <= vc_sum[32:15];
      end
      svpwm_pkg::ST_INJ: begin
        s_u <= level(alpha, cm);
        s_v <= level(vb, cm);
        s_w <= level(vc, cm);
      end
      svpwm_pkg::ST_DV: duty_u <= prod[31:16];
      svpwm_pkg::ST_DW: duty_v <= prod[31:16];
      default:          ;
    endcase
    if (load_out) begin
      m_axis_tdata <= {angle, prod[31:16], duty_v, duty_u};
    end
  end

`ifndef SYNTH
  a_acc_holds: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tvalid && s_axis_tready) |=> $stable(acc))
    else $error("phase accumulator moved without an accepted beat");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == svpwm_pkg::ST_DONE))
    else $error("result loaded outside the final step");

  a_levels_saturated: assert property (@(posedge clk) disable iff (rst)
    (state == svpwm_pkg::ST_DU) |->
      (s_u <= 17'd65536) && (s_v <= 17'd65536) && (s_w <= 17'd65536))
    else $error("phase level outside the saturation range");
`endif

endmodule

FILE: hdl/svpwm_sine.sv
module svpwm_sine (
  input  logic [15:0]        angle,
  output logic signed [15:0] sine
);

  localparam int ADDR_W = svpwm_pkg::SINE_ADDR_BITS + 1;

  logic [14:0]                            rom [0:svpwm_pkg::SINE_DEPTH];
  logic [1:0]                             quad;
  logic [svpwm_pkg::SINE_ADDR_BITS-1:0]   idx;
  logic [ADDR_W-1:0]                      addr;
  logic [14:0]                            mag;

  for (genvar k = 0; k <= svpwm_pkg::SINE_DEPTH; k++) begin : g_rom
    assign rom[k] = 15'(svpwm_pkg::rom_entry(k));
  end

  assign quad = angle[15:14];
  assign idx  = angle[13 -: svpwm_pkg::SINE_ADDR_BITS];

  // Odd quadrants run the table backwards; the upper half-turn is negated.
  always_comb begin
    if (quad[0]) begin
      addr = ADDR_W'(svpwm_pkg::SINE_DEPTH) - {1'b0, idx};
    end else begin
      addr = {1'b0, idx};
    end
    mag = rom[addr];
    if (quad[1]) begin
      sine = -$signed({1'b0, mag});
    end else begin
      sine = $signed({1'b0, mag});
    end
  end

endmodule

FILE: hdl/svpwm_mul.sv
module svpwm_mul (
  input  logic               clk,
  input  logic signed [17:0] a,
  input  logic signed [17:0] b,
  output logic signed [35:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: sim/svpwm_checker.sv
`timescale 1ns / 1ps

module svpwm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero fill
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // duty_u, duty_v, duty_w, electrical_angle
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          results_outstanding,
  output int          mismatches
);

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] duty_w;
    logic [15:0] duty_v;
    logic [15:0] duty_u;
  } duty_beat_t;

  longint      quarter_sine [0:svpwm_pkg::SINE_DEPTH];
  duty_beat_t  duties_due [$];
  logic [14:0] amplitude;
  logic [15:0] step;
  logic [15:0] period;
  logic [15:0] phase;

  // Quarter-wave sine in Q0.15, built from a Q30 Taylor series of sin().
  initial begin : build_quarter_sine
    longint th;
    longint th2;
    longint term;
    longint sum;
    longint v;
    for (int k = 0; k <= svpwm_pkg::SINE_DEPTH; k++) begin
      th   = (svpwm_pkg::HALF_PI_Q30 * longint'(k)) / svpwm_pkg::SINE_DEPTH;
      th2  = (th * th) >>> 30;
      term = th;
      sum  = th;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * th2) >>> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
      quarter_sine[k] = (v > 32767) ? 64'sd32767 : v;
    end
  end

  function automatic longint sine_q15(input logic [15:0] angle);
    int     idx;
    longint v;
    idx = (int'(angle[13:0]) * svpwm_pkg::SINE_DEPTH) >> 14;
    v   = angle[14] ? quarter_sine[svpwm_pkg::SINE_DEPTH - idx] : quarter_sine[idx];
    return angle[15] ? -v : v;
  endfunction

  function automatic logic [15:0] compare_value(input longint p, input logic [15:0] per);
    longint s;
    s = p + 32768;
    if (s < 0) begin
      s = 0;
    end
    if (s > 65536) begin
      s = 65536;
    end
    return 16'((s * longint'(per)) >>> 16);
  endfunction

  function automatic duty_beat_t svpwm_duties(input logic [15:0] angle,
                                              input logic [14:0] amp,
                                              input logic [15:0] per);
    longint     alpha;
    longint     beta;
    longint     vu;
    longint     vv;
    longint     vw;
    longint     hi;
    longint     lo;
    longint     cm;
    duty_beat_t r;
    alpha = (longint'(amp) * sine_q15(angle + 16'd16384) + 16384) >>> 15;
    beta  = (longint'(amp) * sine_q15(angle) + 16384) >>> 15;
    vu = alpha;
    vv = (-16384 * alpha + longint'(svpwm_pkg::SQRT3_HALF_Q15) * beta + 16384) >>> 15;
    vw = (-16384 * alpha - longint'(svpwm_pkg::SQRT3_HALF_Q15) * beta + 16384) >>> 15;
    hi = vu;
    lo = vu;
    if (vv > hi) hi = vv;
    if (vw > hi) hi = vw;
    if (vv < lo) lo = vv;
    if (vw < lo) lo = vw;
    // Min-max injection: shift all three phases by the mid-range offset.
    cm = (hi + lo) >>> 1;
    r.duty_u = compare_value(vu - cm, per);
    r.duty_v = compare_value(vv - cm, per);
    r.duty_w = compare_value(vw - cm, per);
    r.angle  = angle;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] due,
                                      input logic [15:0] seen);
    if (due !== seen) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, due, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    duty_beat_t seen;
    duty_beat_t due;
    if (rst) begin
      amplitude = svpwm_pkg::AMPLITUDE_RESET;
      step      = svpwm_pkg::PHASE_STEP_RESET;
      period    = svpwm_pkg::PWM_PERIOD_RESET;
      phase     = '0;
      duties_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          svpwm_pkg::REG_AMPLITUDE:  amplitude = cfg_data[14:0];
          svpwm_pkg::REG_PHASE_STEP: step      = cfg_data;
          svpwm_pkg::REG_PWM_PERIOD: period    = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tdata[0]) begin
          phase = phase + step;
        end
        duties_due.push_back(svpwm_duties(phase, amplitude, period));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        if (duties_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          due = duties_due.pop_front();
          check_field("duty_u", due.duty_u, seen.duty_u);
          check_field("duty_v", due.duty_v, seen.duty_v);
          check_field("duty_w", due.duty_w, seen.duty_w);
          check_field("electrical_angle", due.angle, seen.angle);
        end
      end
    end
    results_outstanding = duties_due.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 100;
  localparam int RANDOM_PHASES   = 9;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int results_outstanding;
  int mismatches;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_requests;
  int cycle_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  open_loop_svpwm_modulator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  svpwm_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tdata        (m_axis_tdata),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .results_outstanding (results_outstanding),
    .mismatches          (mismatches)
  );

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin : sink
    int held;
    int hold_left;
    if (hold_requests != held) begin
      held      = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SENDER:   begin src_idle_pct = 73; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 73; end
      default:       begin src_idle_pct = 26; sink_stall_pct = 26; end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken
  // with tvalid still high, so back-to-back beats need no gap.
  task automatic push_tick(input logic tick, input logic [6:0] fill);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fill, tick};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic stop_and_drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (results_outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_amplitude();
    case ($urandom_range(4))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(255));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return svpwm_pkg::PWM_PERIOD_RESET;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    set_idling(IDLE_NONE);
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Reset defaults, including a held phase right out of reset.
    push_tick(1'b0, 7'h00);
    push_tick(1'b1, 7'h00);
    push_tick(1'b1, 7'h7F);
    stop_and_drain();

    // Full amplitude, quarter-turn steps through every quadrant, then a hold.
    write_reg(svpwm_pkg::REG_AMPLITUDE, 16'h7FFF);
    write_reg(svpwm_pkg::REG_PHASE_STEP, 16'h4000);
    write_reg(svpwm_pkg::REG_PWM_PERIOD, 16'hFFFF);
    repeat (4) push_tick(1'b1, 7'h00);
    push_tick(1'b0, 7'h00);
    stop_and_drain();

    // Eighth-turn steps land on the octant boundaries.
    write_reg(svpwm_pkg::REG_PHASE_STEP, 16'h2000);
    repeat (8) push_tick(1'b1, 7'h00);
    stop_and_drain();

    // Top amplitude bit is not part of the register; the step wraps backwards.
    write_reg(svpwm_pkg::REG_AMPLITUDE, 16'hFFFF);
    write_reg(svpwm_pkg::REG_PHASE_STEP, 16'hFFFF);
    write_reg(svpwm_pkg::REG_PWM_PERIOD, 16'd1);
    repeat (2) push_tick(1'b1, 7'h00);
    stop_and_drain();

    // Zero period forces every duty to zero; the spare index must do nothing.
    write_reg(svpwm_pkg::REG_PWM_PERIOD, 16'd0);
    write_reg(REG_SPARE, 16'hFFFF);
    repeat (2) push_tick(1'b1, 7'h00);
    stop_and_drain();

    write_reg(svpwm_pkg::REG_AMPLITUDE, 16'd0);
    write_reg(svpwm_pkg::REG_PWM_PERIOD, svpwm_pkg::PWM_PERIOD_RESET);
    repeat (2) push_tick(1'b1, 7'h00);
    stop_and_drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idling(idling_t'(p % 4));
      if (p == 0) begin
        write_reg(svpwm_pkg::REG_AMPLITUDE, 16'h7FFF);
        write_reg(svpwm_pkg::REG_PHASE_STEP, 16'hFFFF);
        write_reg(svpwm_pkg::REG_PWM_PERIOD, 16'hFFFF);
      end else if (p == 1) begin
        write_reg(svpwm_pkg::REG_AMPLITUDE, 16'h0000);
        write_reg(svpwm_pkg::REG_PHASE_STEP, 16'h0000);
        write_reg(svpwm_pkg::REG_PWM_PERIOD, 16'd1);
      end else begin
        write_reg(svpwm_pkg::REG_AMPLITUDE, pick_amplitude());
        write_reg(svpwm_pkg::REG_PHASE_STEP, pick_step());
        write_reg(svpwm_pkg::REG_PWM_PERIOD, pick_period());
      end
      if ($urandom_range(3) == 0) begin
        write_reg(REG_SPARE, 16'($urandom_range(65535)));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Back-pressure test: the result side holds off while ticks keep coming,
        // later the tick stream pauses until everything has come out.
        if (p == 4 && i == 10) hold_requests++;
        if (p == 4 && i == 60) stop_and_drain();
        push_tick($urandom_range(99) < 85, 7'($urandom_range(127)));
      end
      stop_and_drain();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
